// ===== sv/double_ended_queue_macros.svh =====
// assertion macros shared by the double-ended queue checker
// no dependencies; the including module provides clk_i and rst_ni
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// shared types for the double-ended queue: opcodes, status codes,
// controller states and the controller-to-datapath command group
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_RANGE     = 2'd2,
    ST_PUSH_FULL = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic latch;  // capture request fields
    logic exec;   // run the operation on the store and pointers
    logic load;   // fill the result register
  } deq_cmd_t;

endpackage

`default_nettype wire

// ===== sv/deq_dp.sv =====
// datapath of the double-ended queue: element memory, head pointer,
// count and result register; uses deq_pkg, driven by deq_ctrl commands
`default_nettype none

module deq_dp #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IN_W = ((3 + WIDTH + PW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((WIDTH + 2 + CW + 1 + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire deq_pkg::deq_cmd_t cmd_i,
  input  wire logic [IN_W-1:0]   in_data_i,
  output logic      [OUT_W-1:0]  out_data_o
);

  localparam logic [PW:0] DEPTH_X = (PW + 1)'(DEPTH);

  logic [2:0]       op_q;
  logic [WIDTH-1:0] val_q;
  logic [PW-1:0]    idx_q;
  logic [PW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  deq_pkg::st_e     st_q, st_d;
  logic             rd_ok_q, rd_ok_d;
  logic [WIDTH-1:0] rd_data_q;
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [OUT_W-1:0] out_q, out_d;

  logic          full, empty, in_range, wr_en;
  logic [PW-1:0] head_inc, head_dec, back_slot, read_slot, wr_slot;

  // circular wrap of head plus offset, sum stays below twice the depth
  function automatic logic [PW-1:0] wrap_slot(input logic [PW:0] s);
    logic [PW:0] t;
    t = s - DEPTH_X;
    return (s >= DEPTH_X) ? t[PW-1:0] : s[PW-1:0];
  endfunction

  always_comb begin
    full      = (count_q == CW'(DEPTH));
    empty     = (count_q == '0);
    head_inc  = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
    head_dec  = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
    back_slot = wrap_slot({1'b0, head_q} + {1'b0, count_q[PW-1:0]});
    read_slot = wrap_slot({1'b0, head_q} + {1'b0, idx_q});
    in_range  = (CW'(idx_q) < count_q);

    st_d    = deq_pkg::ST_OK;
    rd_ok_d = 1'b0;
    wr_en   = 1'b0;
    wr_slot = back_slot;
    head_d  = head_q;
    count_d = count_q;
    unique case (deq_pkg::op_e'(op_q))
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st_d = deq_pkg::ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st_d = deq_pkg::ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_slot = head_dec;
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          st_d = deq_pkg::ST_POP_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st_d = deq_pkg::ST_POP_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
      end
      deq_pkg::OP_READ: begin
        if (in_range) begin
          rd_ok_d = 1'b1;
        end else begin
          st_d = deq_pkg::ST_RANGE;
        end
      end
      default: begin
        st_d = deq_pkg::ST_OK;
      end
    endcase
  end

  // result word: read value, status, count, empty flag, zero pad
  always_comb begin
    out_d                  = '0;
    out_d[0 +: WIDTH]      = rd_ok_q ? rd_data_q : '0;
    out_d[WIDTH +: 2]      = st_q;
    out_d[WIDTH + 2 +: CW] = count_q;
    out_d[WIDTH + 2 + CW]  = (count_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_data_i[0 +: 3];
      val_q <= in_data_i[3 +: WIDTH];
      idx_q <= in_data_i[3 + WIDTH +: PW];
    end
    if (cmd_i.exec) begin
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
    end
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  // element store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_slot] <= val_q;
    end
    if (cmd_i.exec) begin
      rd_data_q <= mem_q[read_slot];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// controller of the double-ended queue: request sequencing and result valid
// uses deq_pkg; issues commands to deq_dp
`default_nettype none

module deq_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);

  deq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        state_d = deq_pkg::S_RESP;
      end
      deq_pkg::S_RESP: begin
        if (slot_free) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      deq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      deq_pkg::S_RESP: begin
        cmd_o.load = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// top level of the bounded double-ended queue
// uses deq_pkg, deq_ctrl and deq_dp
//
// usage:
//   one request on the slave stream asks for one operation: push back,
//   push front, pop back, pop front, or read at a position from the front.
//   every request returns exactly one result on the master stream with the
//   read value (zero unless a good read), a status code, the count after
//   the operation and an empty flag.
//   a push to a full queue, a pop on an empty queue and a read at or past
//   the count are refused with a status code and leave the queue as it was;
//   unused opcodes do nothing and report ok.
// timing:
//   requests are handled one at a time; a request is taken in the idle
//   state, the store access and pointer update happen in the execute
//   state, and the result register is loaded in the response state once
//   the result slot is free; only then is the next request taken.
//   the registered read port of the element memory calls for that separate load state.
// stall:
//   while the receiver holds tready low the result waits in its register;
//   one more request may be taken and executed, then the block holds.
// reset:
//   asynchronous, active low; clears head pointer, count and handshake
//   state; the element memory keeps its contents and needs no clearing
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16,  // capacity in elements
  parameter int unsigned WIDTH = 32,  // element width
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IN_W = ((3 + WIDTH + PW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((WIDTH + 2 + CW + 1 + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // opcode, value, index, zero pad
  // result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata    // read_value, status, count, is_empty, pad
);

  deq_pkg::deq_cmd_t cmd;

  // sequencing of request, execution and result load
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // circular store with head pointer and count, result register
  deq_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/deq_chk.sv =====
// port-level checker for the double-ended queue and its bind
// uses double_ended_queue_macros.svh; attaches to double_ended_queue
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_chk #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned OUT_W = ((WIDTH + 2 + CW + 1 + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  logic             in_req;
  logic             out_stall;
  logic             res_err;
  logic [WIDTH-1:0] rd_val;
  logic [1:0]       st;
  logic [CW-1:0]    cnt;
  logic             emp;

  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign rd_val    = m_axis_tdata[0 +: WIDTH];
  assign st        = m_axis_tdata[WIDTH +: 2];
  assign cnt       = m_axis_tdata[WIDTH + 2 +: CW];
  assign emp       = m_axis_tdata[WIDTH + 2 + CW];
  assign res_err   = m_axis_tvalid && (st != deq_pkg::ST_OK);

  // a stalled result holds
  `DEQ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result moved")
  // requests are handled one at a time
  `DEQ_ASSERT_NEXT(a_one_at_a_time, in_req, !s_axis_tready, "request taken back to back")
  // count never exceeds capacity
  `DEQ_ASSERT_NOW(a_count_bound, m_axis_tvalid, cnt <= CW'(DEPTH), "count above capacity")
  // empty flag agrees with count
  `DEQ_ASSERT_NOW(a_empty_flag, m_axis_tvalid, emp == (cnt == '0), "empty flag wrong")
  // refused operations return no data
  `DEQ_ASSERT_NOW(a_err_zero, res_err, rd_val == '0, "error result carries data")

endmodule

bind double_ended_queue deq_chk #(
  .DEPTH (DEPTH),
  .WIDTH (WIDTH)
) u_deq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
